### src/line_peak_picker_top_n_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the line peak picker
// Shared forms of clocked assertions, gated by the active-low reset.
// ---------------------------------------------------------------------------
`ifndef LINE_PEAK_PICKER_TOP_N_CORE_MACROS_SVH
`define LINE_PEAK_PICKER_TOP_N_CORE_MACROS_SVH

// Check a property at every rising clock edge outside reset
`define LPPT_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Check that a condition never occurs
`define LPPT_ASSERT_NEVER(lbl, cond, msg) \
	`LPPT_ASSERT_CLK(lbl, !(cond), msg)

`endif

### src/lppt_pkg.sv
// ---------------------------------------------------------------------------
// Line peak picker package
// Sizes, register indexes and the controller/datapath handshake types.
// ---------------------------------------------------------------------------
package lppt_pkg;

	// Sizing
	localparam int MAX_PEAKS   = 8;
	localparam int MAX_LENGTH  = 4096;
	localparam int SAMPLE_BITS = 24;

	// Fixed field widths
	localparam int VALUE_W  = 24;
	localparam int POS_W    = 12;
	localparam int COUNT_W  = 4;
	localparam int KEEP_W   = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W    = 24;

	// Derived widths
	localparam int IDX_W  = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
	localparam int CNT_W  = $clog2(MAX_PEAKS + 1);
	localparam int PCNT_W = $clog2(MAX_LENGTH + 1);
	localparam int CMP_W  = (SAMPLE_BITS > VALUE_W) ? SAMPLE_BITS : VALUE_W;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DETECT_THRESHOLD = 1'b0,
		REG_KEEP_COUNT       = 1'b1
	} lppt_reg_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic take;        // accept the input item
		logic rst_idx;     // restart the readout index
		logic load_out;    // load the next result into the output register
		logic clear_line;  // drop the line state
	} lppt_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic out_free;    // output register can take a result this cycle
		logic drain_last;  // the result at the readout index ends the line
	} lppt_status_t;

endpackage

### src/lppt_ifs.sv
// ---------------------------------------------------------------------------
// Line peak picker channels
// Valid/ready channels for the sample stream and the peak results.
// ---------------------------------------------------------------------------
interface lppt_in_if
	import lppt_pkg::*;
	();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] sample;
	logic               line_end;

	modport source (output valid, sample, line_end, input ready);
	modport sink   (input valid, sample, line_end, output ready);
endinterface

interface lppt_out_if
	import lppt_pkg::*;
	();
	logic               valid;
	logic               ready;
	logic [POS_W-1:0]   peak_position;
	logic [VALUE_W-1:0] peak_value;
	logic [COUNT_W-1:0] peaks_found;
	logic               found;
	logic               last_result;

	modport source (output valid, peak_position, peak_value, peaks_found, found,
		last_result, input ready);
	modport sink   (input valid, peak_position, peak_value, peaks_found, found,
		last_result, output ready);
endinterface

### src/lppt_ctrl.sv
// ---------------------------------------------------------------------------
// Line peak picker controller
// Sequences sample intake, the settle state and the table readout.
// ---------------------------------------------------------------------------
module lppt_ctrl
	import lppt_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic         in_line_end,
	output logic         in_ready,
	input  lppt_status_t status,
	output lppt_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_RUN    = 3'b001,
		S_SETTLE = 3'b010,
		S_EMIT   = 3'b100
	} state_t;

	state_t state_q, state_d;

	// Next state and commands
	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		cmd            = '0;
		case (state_q)
			S_RUN: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
				if (in_valid && in_line_end) begin
					state_d = S_SETTLE;
				end
			end
			S_SETTLE: begin
				// let the last pending peak land in the table
				cmd.rst_idx = 1'b1;
				state_d     = S_EMIT;
			end
			S_EMIT: begin
				cmd.load_out = status.out_free;
				if (status.out_free && status.drain_last) begin
					cmd.clear_line = 1'b1;
					state_d        = S_RUN;
				end
			end
			default: begin
				state_d = S_RUN;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RUN;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### src/lppt_datapath.sv
// ---------------------------------------------------------------------------
// Line peak picker datapath
// Neighbor window, peak test, top-N slot table and output register.
// ---------------------------------------------------------------------------
module lppt_datapath
	import lppt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic [VALUE_W-1:0]   in_sample,
	input  lppt_cmd_t            cmd,
	output lppt_status_t         status,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [POS_W-1:0]     out_peak_position,
	output logic [VALUE_W-1:0]   out_peak_value,
	output logic [COUNT_W-1:0]   out_peaks_found,
	output logic                 out_found,
	output logic                 out_last_result
);

	// Configuration
	logic [VALUE_W-1:0] thr_q;
	logic [KEEP_W-1:0]  keep_q;

	// Line state
	logic [SAMPLE_BITS-1:0] prior_q;
	logic [SAMPLE_BITS-1:0] older_q;
	logic [PCNT_W-1:0]      pcnt_q;
	logic [CNT_W-1:0]       filled_q;

	// Candidate stage
	logic                   cand_vld_s1;
	logic [POS_W-1:0]       cand_pos_s1;
	logic [SAMPLE_BITS-1:0] cand_val_s1;

	// Slot table
	logic [POS_W-1:0]       slot_pos_q [MAX_PEAKS];
	logic [SAMPLE_BITS-1:0] slot_val_q [MAX_PEAKS];

	// Readout
	logic [IDX_W-1:0]   drain_idx_q;
	logic               out_valid_q;
	logic [POS_W-1:0]   out_pos_q;
	logic [VALUE_W-1:0] out_val_q;
	logic [COUNT_W-1:0] out_cnt_q;
	logic               out_found_q;
	logic               out_last_q;

	logic [SAMPLE_BITS-1:0] samp;
	logic                   in_line;
	logic                   is_peak;
	logic [CNT_W-1:0]       eff_keep;
	logic [IDX_W-1:0]       low_idx;
	logic [SAMPLE_BITS-1:0] low_val;
	logic                   do_fill;
	logic                   do_replace;
	logic [IDX_W-1:0]       wr_idx;
	logic [CNT_W-1:0]       idx_next;

	assign samp    = SAMPLE_BITS'(in_sample);
	assign in_line = (pcnt_q < PCNT_W'(MAX_LENGTH));

	// Peak test on the middle sample of the window
	assign is_peak = (pcnt_q >= PCNT_W'(2))
		&& (CMP_W'(prior_q) > CMP_W'(thr_q))
		&& (prior_q > samp)
		&& (prior_q > older_q);

	// Clamp keep_count to 1..MAX_PEAKS
	always_comb begin
		if (keep_q == '0) begin
			eff_keep = CNT_W'(1);
		end else if (32'(keep_q) > 32'(MAX_PEAKS)) begin
			eff_keep = CNT_W'(MAX_PEAKS);
		end else begin
			eff_keep = CNT_W'(keep_q);
		end
	end

	// Lowest entry among the slots in use, lowest slot on ties
	always_comb begin
		low_idx = '0;
		low_val = slot_val_q[0];
		for (int m = 1; m < MAX_PEAKS; m++) begin
			if ((CNT_W'(m) < eff_keep) && (slot_val_q[m] < low_val)) begin
				low_val = slot_val_q[m];
				low_idx = IDX_W'(m);
			end
		end
	end

	assign do_fill    = cand_vld_s1 && (filled_q < eff_keep);
	assign do_replace = cand_vld_s1 && !(filled_q < eff_keep) && (cand_val_s1 > low_val);
	assign wr_idx     = do_fill ? IDX_W'(filled_q) : low_idx;

	// Status to the controller
	assign idx_next          = CNT_W'(drain_idx_q) + CNT_W'(1);
	assign status.out_free   = !out_valid_q || out_ready;
	assign status.drain_last = (filled_q == '0) || (idx_next == filled_q);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= '0;
			keep_q <= KEEP_W'(8);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DETECT_THRESHOLD: thr_q  <= VALUE_W'(cfg_wdata);
				REG_KEEP_COUNT:       keep_q <= KEEP_W'(cfg_wdata);
				default: begin
				end
			endcase
		end
	end

	// Window, position count, candidate and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_q     <= '0;
			older_q     <= '0;
			pcnt_q      <= '0;
			filled_q    <= '0;
			cand_vld_s1 <= 1'b0;
		end else begin
			cand_vld_s1 <= 1'b0;
			if (cmd.take && in_line) begin
				cand_vld_s1 <= is_peak;
				older_q     <= prior_q;
				prior_q     <= samp;
				pcnt_q      <= pcnt_q + PCNT_W'(1);
			end
			if (do_fill) begin
				filled_q <= filled_q + CNT_W'(1);
			end
			if (cmd.clear_line) begin
				prior_q  <= '0;
				older_q  <= '0;
				pcnt_q   <= '0;
				filled_q <= '0;
			end
		end
	end

	// Candidate payload
	always_ff @(posedge clk) begin
		if (cmd.take && in_line) begin
			cand_pos_s1 <= POS_W'(pcnt_q - PCNT_W'(1));
			cand_val_s1 <= prior_q;
		end
	end

	// Slot table write
	always_ff @(posedge clk) begin
		if (do_fill || do_replace) begin
			slot_pos_q[wr_idx] <= cand_pos_s1;
			slot_val_q[wr_idx] <= cand_val_s1;
		end
	end

	// Readout index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.rst_idx) begin
				drain_idx_q <= '0;
			end else if (cmd.load_out) begin
				drain_idx_q <= drain_idx_q + IDX_W'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (filled_q == '0) begin
				out_pos_q   <= '0;
				out_val_q   <= '0;
				out_cnt_q   <= '0;
				out_found_q <= 1'b0;
				out_last_q  <= 1'b1;
			end else begin
				out_pos_q   <= slot_pos_q[drain_idx_q];
				out_val_q   <= VALUE_W'(slot_val_q[drain_idx_q]);
				out_cnt_q   <= COUNT_W'(filled_q);
				out_found_q <= 1'b1;
				out_last_q  <= (idx_next == filled_q);
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign out_peak_position = out_pos_q;
	assign out_peak_value    = out_val_q;
	assign out_peaks_found   = out_cnt_q;
	assign out_found         = out_found_q;
	assign out_last_result   = out_last_q;

endmodule

### src/line_peak_picker_top_n_core.sv
// Throughput: one sample per cycle while a line streams in.
// Readout: after line_end is taken and the settle state passes, the emit state loads
// the results one per cycle as the sink takes them; intake resumes as the last loads.
// Reset: arst_n clears the line state, the output valid flag and the registers
// (detect_threshold 0, keep_count 8); the slot table is not cleared.
// ---------------------------------------------------------------------------
// Line peak picker, top level
// Streams a line of samples, keeps the strongest local maxima, reads them out.
// ---------------------------------------------------------------------------
module line_peak_picker_top_n_core
	import lppt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	lppt_in_if.sink              in_ch,
	lppt_out_if.source           out_ch
);

	lppt_cmd_t    cmd;
	lppt_status_t status;

	// Sequencer
	lppt_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_ch.valid),
		.in_line_end (in_ch.line_end),
		.in_ready    (in_ch.ready),
		.status      (status),
		.cmd         (cmd)
	);

	// Window, table and output register
	lppt_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.in_sample         (in_ch.sample),
		.cmd               (cmd),
		.status            (status),
		.out_ready         (out_ch.ready),
		.out_valid         (out_ch.valid),
		.out_peak_position (out_ch.peak_position),
		.out_peak_value    (out_ch.peak_value),
		.out_peaks_found   (out_ch.peaks_found),
		.out_found         (out_ch.found),
		.out_last_result   (out_ch.last_result)
	);

endmodule

### src/lppt_checker.sv
// ---------------------------------------------------------------------------
// Line peak picker checker
// Port-level checks on intake, readout sequencing and result fields.
// ---------------------------------------------------------------------------
`include "line_peak_picker_top_n_core_macros.svh"

module lppt_checker
	import lppt_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               in_line_end,
	input logic               out_valid,
	input logic               out_ready,
	input logic [COUNT_W-1:0] out_peaks_found,
	input logic               out_found,
	input logic               out_last_result
);

	// A stalled result stays offered
	`LPPT_ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

	// Intake stops once a line end is taken
	`LPPT_ASSERT_CLK(a_end_stall, in_valid && in_ready && in_line_end |=> !in_ready, "item taken after line end")

	// Readout of a line runs without gaps
	`LPPT_ASSERT_CLK(a_drain_run, out_valid && out_ready && !out_last_result |=> out_valid, "gap inside readout")

	// Result fields agree with each other
	`LPPT_ASSERT_NEVER(a_fields, out_valid && ((!out_found && (!out_last_result || out_peaks_found != '0)) || (out_found && (out_peaks_found == '0 || 32'(out_peaks_found) > MAX_PEAKS))), "inconsistent result fields")

endmodule

bind line_peak_picker_top_n_core lppt_checker u_lppt_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_ch.valid),
	.in_ready        (in_ch.ready),
	.in_line_end     (in_ch.line_end),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.out_peaks_found (out_ch.peaks_found),
	.out_found       (out_ch.found),
	.out_last_result (out_ch.last_result)
);

### tb/line_peak_picker_top_n_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Line peak picker testbench
// Streams lines of samples into the picker, tracks the strongest local maxima
// in a behavioral table of its own and compares every result it reads out.
// ---------------------------------------------------------------------------
module line_peak_picker_top_n_core_tb;
	import lppt_pkg::*;

	typedef struct {
		logic [POS_W-1:0]   position;
		logic [VALUE_W-1:0] value;
		logic [COUNT_W-1:0] count;
		logic               found;
		logic               last;
	} peak_rec_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	lppt_in_if  in_ch ();
	lppt_out_if out_ch ();

	line_peak_picker_top_n_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch.sink),
		.out_ch    (out_ch.source)
	);

	// Line tracker: threshold, slot count and the current line's peak table
	logic [VALUE_W-1:0] thr_reg = '0;
	logic [KEEP_W-1:0]  keep_reg = KEEP_W'(8);
	logic [VALUE_W-1:0] prev_s = '0;
	logic [VALUE_W-1:0] older_s = '0;
	int unsigned        line_pos = 0;
	logic [POS_W-1:0]   tbl_pos [MAX_PEAKS];
	logic [VALUE_W-1:0] tbl_val [MAX_PEAKS];
	int unsigned        tbl_fill = 0;

	peak_rec_t   pending_peaks [$];
	int unsigned mismatch_cnt = 0;
	int unsigned burst_left = 0;
	int unsigned random_sent = 0;
	int unsigned sink_mode = 0;
	int unsigned mode_cycles = 0;

	always #1 clk = ~clk;

	// Clamp the slot count the way the block does
	function automatic int unsigned slots_in_use();
		if (keep_reg == 0)
			return 1;
		if (keep_reg > MAX_PEAKS)
			return MAX_PEAKS;
		return 32'(keep_reg);
	endfunction

	// Fill the table, or replace the weakest entry when strictly stronger
	function automatic void offer_to_table(int unsigned pos, logic [VALUE_W-1:0] val);
		int unsigned keep;
		int unsigned low_idx;
		keep = slots_in_use();
		if (tbl_fill < keep) begin
			tbl_pos[tbl_fill] = POS_W'(pos);
			tbl_val[tbl_fill] = val;
			tbl_fill++;
			return;
		end
		low_idx = 0;
		for (int m = 1; m < keep; m++) begin
			if (tbl_val[m] < tbl_val[low_idx])
				low_idx = m;
		end
		if (val > tbl_val[low_idx]) begin
			tbl_pos[low_idx] = POS_W'(pos);
			tbl_val[low_idx] = val;
		end
	endfunction

	// Advance the line by one accepted sample; queue the readout at line end
	function automatic void track_sample(logic [VALUE_W-1:0] s, logic line_end);
		peak_rec_t rec;
		if (line_pos < MAX_LENGTH) begin
			if (line_pos >= 2 && prev_s > thr_reg && prev_s > s && prev_s > older_s)
				offer_to_table(line_pos - 1, prev_s);
			older_s = prev_s;
			prev_s = s;
			line_pos++;
		end
		if (!line_end)
			return;
		if (tbl_fill == 0) begin
			rec = '{position: '0, value: '0, count: '0, found: 1'b0, last: 1'b1};
			pending_peaks.push_back(rec);
		end else begin
			for (int k = 0; k < tbl_fill; k++) begin
				rec.position = tbl_pos[k];
				rec.value = tbl_val[k];
				rec.count = COUNT_W'(tbl_fill);
				rec.found = 1'b1;
				rec.last = (k + 1 == tbl_fill);
				pending_peaks.push_back(rec);
			end
		end
		prev_s = '0;
		older_s = '0;
		line_pos = 0;
		tbl_fill = 0;
	endfunction

	function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", fname, want, got);
			mismatch_cnt++;
		end
	endfunction

	// Send one item; hold it until taken, then idle in bursts
	task automatic send_item(logic [VALUE_W-1:0] s, logic line_end);
		int unsigned gap;
		in_ch.valid = 1'b1;
		in_ch.sample = s;
		in_ch.line_end = line_end;
		do
			@(posedge clk);
		while (!in_ch.ready);
		track_sample(s, line_end);
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end else begin
			burst_left--;
		end
	endtask

	// Stop sending and wait until every queued result is read out
	task automatic wait_drain();
		in_ch.valid = 1'b0;
		while (pending_peaks.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(lppt_reg_t idx, logic [CFG_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		@(posedge clk);
		if (idx == REG_DETECT_THRESHOLD)
			thr_reg = data[VALUE_W-1:0];
		else
			keep_reg = data[KEEP_W-1:0];
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic send_line(logic [VALUE_W-1:0] vals [$]);
		foreach (vals[i])
			send_item(vals[i], i == vals.size() - 1);
	endtask

	// Line of isolated peaks at the odd positions, zeros in between
	task automatic send_peak_train(logic [VALUE_W-1:0] heights [$]);
		logic [VALUE_W-1:0] line [$];
		line.push_back('0);
		foreach (heights[i]) begin
			line.push_back(heights[i]);
			line.push_back('0);
		end
		send_line(line);
	endtask

	// Lines too short for a peak, a flat line and a rising line
	task automatic test_empty_lines();
		send_line('{24'hFFFFFF});
		send_line('{24'h000000, 24'hFFFFFF});
		send_line('{24'h000005, 24'h000005, 24'h000005});
		send_line('{24'h000001, 24'h000002, 24'hFFFFFF});
	endtask

	// Simple peaks, plateaus, and the full value range
	task automatic test_basic_peaks();
		wait_drain();
		write_reg(REG_DETECT_THRESHOLD, '0);
		write_reg(REG_KEEP_COUNT, CFG_W'(8));
		send_line('{24'h000000, 24'hFFFFFF, 24'h000000, 24'h000005, 24'h000006,
			24'h000005});
		send_line('{24'h000001, 24'h000007, 24'h000007, 24'h000001, 24'hAAAAAA,
			24'h555555});
	endtask

	// Peak must be strictly above the threshold
	task automatic test_threshold();
		wait_drain();
		write_reg(REG_DETECT_THRESHOLD, 24'hFFFFFE);
		send_peak_train('{24'hFFFFFE, 24'hFFFFFF, 24'h7FFFFF});
		wait_drain();
		write_reg(REG_DETECT_THRESHOLD, 24'hFFFFFF);
		send_peak_train('{24'hFFFFFF, 24'hFFFFFE});
	endtask

	// Replacement of the weakest slot, ties going to the lowest slot
	task automatic test_replacement();
		wait_drain();
		write_reg(REG_DETECT_THRESHOLD, 24'h000003);
		write_reg(REG_KEEP_COUNT, CFG_W'(2));
		send_peak_train('{24'd10, 24'd20, 24'd15, 24'd15, 24'd14, 24'd30});
		send_peak_train('{24'd10, 24'd10, 24'd11, 24'd10});
	endtask

	// Slot counts at and beyond their limits
	task automatic test_keep_extremes();
		wait_drain();
		write_reg(REG_DETECT_THRESHOLD, '0);
		write_reg(REG_KEEP_COUNT, CFG_W'(0));
		send_peak_train('{24'd5, 24'd9, 24'd7});
		wait_drain();
		write_reg(REG_KEEP_COUNT, CFG_W'(15));
		send_peak_train('{24'd1, 24'd2, 24'd3, 24'd4, 24'd5, 24'd6, 24'd7, 24'd8, 24'd9,
			24'd2});
		wait_drain();
		write_reg(REG_KEEP_COUNT, CFG_W'(1));
		send_peak_train('{24'd4, 24'd3, 24'd8});
	endtask

	// Lower the slot count in the middle of a line
	task automatic test_keep_lowered_mid_line();
		wait_drain();
		write_reg(REG_KEEP_COUNT, CFG_W'(8));
		send_item(24'd0, 1'b0);
		for (int i = 0; i < 4; i++) begin
			send_item(VALUE_W'(40 + i), 1'b0);
			send_item(24'd0, 1'b0);
		end
		wait_drain();
		write_reg(REG_KEEP_COUNT, CFG_W'(2));
		send_item(24'd100, 1'b0);
		send_item(24'd0, 1'b0);
		send_item(24'd39, 1'b0);
		send_item(24'd0, 1'b1);
	endtask

	// Line past the maximum length: the tail is ignored but still ends the line
	task automatic test_long_line();
		logic [VALUE_W-1:0] v;
		wait_drain();
		write_reg(REG_KEEP_COUNT, CFG_W'(3));
		for (int i = 0; i < MAX_LENGTH + 4; i++) begin
			case (i)
				10:      v = 24'd100;
				2000:    v = 24'd50;
				3000:    v = 24'd60;
				4093:    v = 24'd1;
				4094:    v = 24'h800000;
				4095:    v = 24'd2;
				4096:    v = 24'd1;
				4097:    v = 24'h00FFFF;
				default: v = '0;
			endcase
			send_item(v, i == MAX_LENGTH + 3);
		end
	endtask

	// Random lines under changing settings
	task automatic test_random_lines();
		int unsigned len;
		int unsigned style;
		int unsigned lines_left;
		logic [VALUE_W-1:0] v;
		lines_left = 0;
		while (random_sent < 420) begin
			if (lines_left == 0) begin
				wait_drain();
				case ($urandom_range(0, 5))
					0:       v = '0;
					1:       v = 24'hFFFFFF;
					2:       v = VALUE_W'($urandom_range(0, 4));
					3:       v = VALUE_W'($urandom);
					default: v = VALUE_W'($urandom_range(0, 24'h3FFFFF));
				endcase
				write_reg(REG_DETECT_THRESHOLD, v);
				v = ($urandom_range(0, 4) == 0) ? VALUE_W'($urandom_range(0, 15))
					: VALUE_W'($urandom_range(1, 8));
				write_reg(REG_KEEP_COUNT, v);
				lines_left = $urandom_range(2, 8);
			end
			lines_left--;
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 160) : $urandom_range(1, 40);
			style = $urandom_range(0, 3);
			for (int i = 0; i < len; i++) begin
				case (style)
					0:       v = VALUE_W'($urandom);
					1:       v = VALUE_W'($urandom_range(0, 7));
					2:       v = (i % 2) ? VALUE_W'($urandom) : VALUE_W'($urandom_range(0, 255));
					default: v = 24'hFFFFF0 | VALUE_W'($urandom_range(0, 15));
				endcase
				send_item(v, i == len - 1);
				random_sent++;
			end
		end
	endtask

	// Result sink: stall in changing patterns
	always @(negedge clk) begin
		if (mode_cycles == 0) begin
			sink_mode = $urandom_range(0, 3);
			mode_cycles = $urandom_range(20, 120);
		end else begin
			mode_cycles--;
		end
		case (sink_mode)
			0:       out_ch.ready = 1'b1;
			1:       out_ch.ready = 1'($urandom_range(0, 1));
			2:       out_ch.ready = ($urandom_range(0, 7) == 0);
			default: out_ch.ready = ($urandom_range(0, 15) != 0);
		endcase
	end

	// Compare each taken result with the oldest expected peak
	always @(posedge clk) begin
		peak_rec_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_peaks.size() == 0) begin
				$error("unexpected result: position %0d value %0h", out_ch.peak_position,
					out_ch.peak_value);
				mismatch_cnt++;
			end else begin
				want = pending_peaks.pop_front();
				check_field("peak_position", 32'(want.position), 32'(out_ch.peak_position));
				check_field("peak_value", 32'(want.value), 32'(out_ch.peak_value));
				check_field("peaks_found", 32'(want.count), 32'(out_ch.peaks_found));
				check_field("found", 32'(want.found), 32'(out_ch.found));
				check_field("last_result", 32'(want.last), 32'(out_ch.last_result));
			end
		end
	end

	// Watchdog
	initial begin
		#2000000;
		$display("** line_peak_picker_top_n_core: FAILED **");
		$finish;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.sample = '0;
		in_ch.line_end = 1'b0;
		out_ch.ready = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_lines();
		test_basic_peaks();
		test_threshold();
		test_replacement();
		test_keep_extremes();
		test_keep_lowered_mid_line();
		test_long_line();
		test_random_lines();

		wait_drain();
		repeat (10) @(negedge clk);
		if (mismatch_cnt == 0)
			$display("** line_peak_picker_top_n_core: PASSED **");
		else
			$display("** line_peak_picker_top_n_core: FAILED **");
		$finish;
	end

endmodule

### line_peak_picker_top_n_core.f
+incdir+src
src/lppt_pkg.sv
src/lppt_ifs.sv
src/lppt_ctrl.sv
src/lppt_datapath.sv
src/line_peak_picker_top_n_core.sv
src/lppt_checker.sv
tb/line_peak_picker_top_n_core_tb.sv
